FILE: hw/rtl/spz_pkg.sv
// ----------------------------------------------------------------------------
// spz_pkg - shared types and constants for the Spritz sponge engine
// Operation codes and sequencer states.
// ----------------------------------------------------------------------------
package spz_pkg;

  localparam int unsigned N = 256;
  localparam logic [7:0] HALF = 8'd128;
  localparam logic [7:0] TOP = 8'd255;
  localparam logic [7:0] NIB_MASK = 8'd15;
  localparam logic [7:0] W_STEP = 8'd2;

  typedef enum logic [1:0] {
    KIND_INIT   = 2'd0,
    KIND_ABSORB = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_DRIP   = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_DISPATCH,
    ST_UPD_I,
    ST_UPD_J1,
    ST_UPD_J2,
    ST_UPD_K,
    ST_UPD_SW,
    ST_CR_RD1,
    ST_CR_RD2,
    ST_CR_CMP,
    ST_CR_WR,
    ST_AB_RD1,
    ST_AB_RD2,
    ST_AB_WR1,
    ST_AB_WR2,
    ST_Z_RD1,
    ST_Z_RD2,
    ST_Z_RD3,
    ST_Z_DONE,
    ST_OUT
  } state_t;

endpackage

FILE: hw/rtl/spritz_sponge_engine_top.sv
// ----------------------------------------------------------------------------
// spritz_sponge_engine_top - Spritz sponge engine over a 256-byte permutation
// Sequence: an absorb byte runs, per nibble, a dispatch plus 4 RAM steps;
// a drip runs a dispatch, an update and the z reads, then the out beat; a
// shuffle adds 1536 updates plus two crushes of 128 compare-swap steps each.
// Throughput: one beat at a time; the single-port permutation RAM sets it.
// Reset (and init): RAM swept to the identity, no input beat taken
// meanwhile; i, j, k, z, a cleared and w set to 1.
// ----------------------------------------------------------------------------
module spritz_sponge_engine_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);

  // permutation RAM: one port, registered read data
  logic [7:0] perm [spz_pkg::N];
  logic [7:0] rd_data;
  logic [7:0] addr;
  logic [7:0] wr_data;
  logic       we;

  always_ff @(posedge clk) begin
    if (we) perm[addr] <= wr_data;
    rd_data <= perm[addr];
  end

  spz_pkg::state_t state, state_next;

  logic [7:0] i, j, k, z, a, w;
  logic [7:0] tmp, tmp2;          // held read values
  logic [7:0] cnt;                // sweep / crush index
  logic [2:0] phase;              // shuffle step 0..5
  logic [9:0] ucnt;               // updates left in a whip
  logic       shuf;               // currently shuffling
  logic [1:0] op;
  logic [7:0] dat;
  logic       hi_nib;             // second nibble of an absorb beat

  assign in_ready  = (state == spz_pkg::ST_IDLE);
  assign out_valid = (state == spz_pkg::ST_OUT);
  assign out_byte  = z ^ dat;

  logic need_shuf;
  always_comb begin
    case (spz_pkg::kind_t'(op))
      spz_pkg::KIND_DRIP: need_shuf = (a != 8'd0);
      default:            need_shuf = (a == spz_pkg::HALF);
    endcase
  end

  logic [7:0] nib;
  assign nib = hi_nib ? {4'd0, dat[7:4]} : (dat & spz_pkg::NIB_MASK);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      spz_pkg::ST_IDLE:
        if (in_valid) begin
          if (spz_pkg::kind_t'(kind) == spz_pkg::KIND_INIT) state_next = spz_pkg::ST_INIT;
          else state_next = spz_pkg::ST_DISPATCH;
        end
      spz_pkg::ST_INIT:
        if (cnt == spz_pkg::TOP) state_next = spz_pkg::ST_IDLE;
      spz_pkg::ST_DISPATCH: begin
        if (shuf) begin
          if (phase == 3'd1 || phase == 3'd3) state_next = spz_pkg::ST_CR_RD1;
          else if (phase == 3'd5) state_next = spz_pkg::ST_DISPATCH;
          else state_next = spz_pkg::ST_UPD_I;
        end else if (need_shuf) state_next = spz_pkg::ST_UPD_I;
        else begin
          case (spz_pkg::kind_t'(op))
            spz_pkg::KIND_ABSORB: state_next = spz_pkg::ST_AB_RD1;
            spz_pkg::KIND_STOP:   state_next = spz_pkg::ST_IDLE;
            default:              state_next = spz_pkg::ST_UPD_I;
          endcase
        end
      end
      spz_pkg::ST_UPD_I:  state_next = spz_pkg::ST_UPD_J1;
      spz_pkg::ST_UPD_J1: state_next = spz_pkg::ST_UPD_J2;
      spz_pkg::ST_UPD_J2: state_next = spz_pkg::ST_UPD_K;
      spz_pkg::ST_UPD_K:  state_next = spz_pkg::ST_UPD_SW;
      spz_pkg::ST_UPD_SW: begin
        if (shuf) state_next = (ucnt == 10'd1) ? spz_pkg::ST_DISPATCH : spz_pkg::ST_UPD_I;
        else state_next = spz_pkg::ST_Z_RD1;
      end
      spz_pkg::ST_CR_RD1: state_next = spz_pkg::ST_CR_RD2;
      spz_pkg::ST_CR_RD2: state_next = spz_pkg::ST_CR_CMP;
      spz_pkg::ST_CR_CMP: state_next = spz_pkg::ST_CR_WR;
      spz_pkg::ST_CR_WR:
        state_next = (cnt == 8'd127) ? spz_pkg::ST_DISPATCH : spz_pkg::ST_CR_RD1;
      spz_pkg::ST_AB_RD1: state_next = spz_pkg::ST_AB_RD2;
      spz_pkg::ST_AB_RD2: state_next = spz_pkg::ST_AB_WR1;
      spz_pkg::ST_AB_WR1: state_next = spz_pkg::ST_AB_WR2;
      spz_pkg::ST_AB_WR2: state_next = hi_nib ? spz_pkg::ST_IDLE : spz_pkg::ST_DISPATCH;
      spz_pkg::ST_Z_RD1:  state_next = spz_pkg::ST_Z_RD2;
      spz_pkg::ST_Z_RD2:  state_next = spz_pkg::ST_Z_RD3;
      spz_pkg::ST_Z_RD3:  state_next = spz_pkg::ST_Z_DONE;
      spz_pkg::ST_Z_DONE: state_next = spz_pkg::ST_OUT;
      spz_pkg::ST_OUT:    if (out_ready) state_next = spz_pkg::ST_IDLE;
      default:            state_next = spz_pkg::ST_IDLE;
    endcase
  end

  // RAM port drive; read data comes back registered in rd_data
  always_comb begin
    addr = 8'd0;
    wr_data = 8'd0;
    we = 1'b0;
    case (state)
      spz_pkg::ST_INIT:   begin addr = cnt; wr_data = cnt; we = 1'b1; end
      spz_pkg::ST_UPD_I:  addr = i + w;                 // perm[i'] (i updated here)
      spz_pkg::ST_UPD_J1: addr = j + rd_data;           // tmp = perm[i]
      spz_pkg::ST_UPD_J2: addr = k + rd_data;           // perm[j']
      spz_pkg::ST_UPD_K:  begin addr = i; wr_data = rd_data; we = 1'b1; end
      spz_pkg::ST_UPD_SW: begin addr = j; wr_data = tmp; we = 1'b1; end
      spz_pkg::ST_CR_RD1: addr = cnt;
      spz_pkg::ST_CR_RD2: addr = spz_pkg::TOP - cnt;
      spz_pkg::ST_CR_CMP: begin addr = cnt; wr_data = rd_data; we = (tmp > rd_data); end
      spz_pkg::ST_CR_WR:  begin addr = spz_pkg::TOP - cnt; wr_data = tmp; we = (tmp > tmp2); end
      spz_pkg::ST_AB_RD1: addr = a;
      spz_pkg::ST_AB_RD2: addr = spz_pkg::HALF + nib;
      spz_pkg::ST_AB_WR1: begin addr = a; wr_data = rd_data; we = 1'b1; end
      spz_pkg::ST_AB_WR2: begin addr = spz_pkg::HALF + nib; wr_data = tmp; we = 1'b1; end
      spz_pkg::ST_Z_RD1:  addr = z + k;
      spz_pkg::ST_Z_RD2:  addr = rd_data + i;
      spz_pkg::ST_Z_RD3:  addr = rd_data + j;
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spz_pkg::ST_INIT;
      cnt <= 8'd0; i <= 8'd0; j <= 8'd0; k <= 8'd0; z <= 8'd0; a <= 8'd0;
      w <= 8'd1; shuf <= 1'b0; phase <= 3'd0; hi_nib <= 1'b0; ucnt <= 10'd0;
      op <= 2'd0; dat <= 8'd0;
    end else begin
      state <= state_next;
      case (state)
        spz_pkg::ST_IDLE:
          if (in_valid) begin
            op <= kind; dat <= data_byte; hi_nib <= 1'b0; cnt <= 8'd0;
            if (spz_pkg::kind_t'(kind) == spz_pkg::KIND_INIT) begin
              i <= 8'd0; j <= 8'd0; k <= 8'd0; z <= 8'd0; a <= 8'd0; w <= 8'd1;
            end
          end
        spz_pkg::ST_INIT: cnt <= cnt + 8'd1;
        spz_pkg::ST_DISPATCH: begin
          ucnt <= 10'd512; cnt <= 8'd0;
          if (shuf) begin
            if (phase == 3'd5) begin shuf <= 1'b0; a <= 8'd0; end
          end else if (need_shuf) begin
            shuf <= 1'b1; phase <= 3'd0;
          end else if (spz_pkg::kind_t'(op) == spz_pkg::KIND_STOP) a <= a + 8'd1;
        end
        spz_pkg::ST_UPD_I:  i <= i + w;
        spz_pkg::ST_UPD_J1: tmp <= rd_data;
        spz_pkg::ST_UPD_J2: j <= k + rd_data;
        spz_pkg::ST_UPD_K:  k <= i + k + rd_data;
        spz_pkg::ST_UPD_SW:
          if (shuf) begin
            ucnt <= ucnt - 10'd1;
            if (ucnt == 10'd1) begin
              w <= w + spz_pkg::W_STEP; phase <= phase + 3'd1;
            end
          end
        spz_pkg::ST_CR_RD2: tmp <= rd_data;
        spz_pkg::ST_CR_CMP: tmp2 <= rd_data;
        spz_pkg::ST_CR_WR: begin
          cnt <= cnt + 8'd1;
          if (cnt == 8'd127) phase <= phase + 3'd1;
        end
        spz_pkg::ST_AB_RD2: tmp <= rd_data;
        spz_pkg::ST_AB_WR2: begin a <= a + 8'd1; hi_nib <= 1'b1; end
        spz_pkg::ST_Z_DONE: z <= rd_data;
        default: ;
      endcase
    end
  end

endmodule
